// ===== sv/universal_string_hash_assert.svh =====
// assertion macros for the string hash block
// each macro expects clk and arst_n in the enclosing scope
`ifndef UNIVERSAL_STRING_HASH_ASSERT_SVH
`define UNIVERSAL_STRING_HASH_ASSERT_SVH

// consequent checked in the same cycle
`define USH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("string hash check failed");

// consequent checked in the next cycle
`define USH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("string hash check failed");

`endif

// ===== sv/ush_pkg.sv =====
package ush_pkg;

	// largest table size is 2**INDEX_BITS
	localparam int INDEX_BITS = 16;

	// fixed field widths
	localparam int TSW      = 17;
	localparam int CHAR_W   = 8;
	localparam int BUCKET_W = 16;

	// hash constants
	localparam int HASH_SEED_MULT   = 31415;
	localparam int HASH_STEP_MULT   = 27183;
	localparam int STEP_W           = 15;
	localparam int TABLE_SIZE_RESET = 1024;

	// multiplier register must hold the seed even for small index widths
	localparam int MW  = (INDEX_BITS > STEP_W) ? INDEX_BITS : STEP_W;
	// product widths: a*h + c, and a*step
	localparam int HPW = MW + INDEX_BITS + 1;
	localparam int MPW = MW + STEP_W;
	// common width of the serial reducers
	localparam int PW  = (HPW > MPW) ? HPW : MPW;
	localparam int CNTW = $clog2(PW);

	// compare width for clamping the table size
	localparam int CW = (TSW > INDEX_BITS + 1) ? TSW : INDEX_BITS + 1;

	// apb port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_TABLE_SIZE = '0;

	// reducer control
	typedef struct packed {
		logic load;
		logic step;
	} red_ctrl_t;

endpackage

// ===== sv/ush_reducer.sv =====
module ush_reducer (
	input  logic                          clk,
	input  ush_pkg::red_ctrl_t            ctrl,
	input  logic [ush_pkg::PW-1:0]        product,
	input  logic [ush_pkg::INDEX_BITS:0]  divisor,
	output logic [ush_pkg::INDEX_BITS-1:0] remainder
);
	import ush_pkg::*;

	logic [PW-1:0]         prod_q;
	logic [INDEX_BITS-1:0] rem_q;
	logic [INDEX_BITS:0]   trial;
	logic [INDEX_BITS:0]   diff;

	// next partial remainder: shift in the next product bit, subtract once
	always_comb begin
		trial = {rem_q, prod_q[PW-1]};
		diff  = trial - divisor;
	end

	// restoring reduction, one product bit per cycle while step is high, msb first
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_q <= product;
			rem_q  <= '0;
		end else if (ctrl.step) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			if (trial >= divisor) begin
				rem_q <= diff[INDEX_BITS-1:0];
			end else begin
				rem_q <= trial[INDEX_BITS-1:0];
			end
		end
	end

	assign remainder = rem_q;

endmodule

// ===== sv/universal_string_hash.sv =====
// a nonzero byte occupies the block until the two bit-serial remainder units have
// walked the products one bit a cycle and the new hash and multiplier are stored
// a zero byte needs no reduction and its bucket index shows the next cycle
// a finished index waits in an output register, input stalls while it is held off
// reset: table size 1024, hash 0, multiplier 31415, no pending result
`include "universal_string_hash_assert.svh"

module universal_string_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ush_pkg::APB_AW-1:0]    paddr,
	input  logic [ush_pkg::APB_DW-1:0]    pwdata,
	output logic [ush_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [ush_pkg::CHAR_W-1:0]    char_code,
	output logic                          bucket_valid,
	input  logic                          bucket_stall,
	output logic [ush_pkg::BUCKET_W-1:0]  bucket_index
);
	import ush_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(PW - 1);
	localparam logic [CW-1:0] SIZE_TOP = CW'(1) << INDEX_BITS;
	localparam logic [CW-1:0] SIZE_MIN = CW'(2);

	logic [TSW-1:0]         table_size_q;
	logic [1:0]             state_q;
	logic [CNTW-1:0]        cnt_q;
	logic [INDEX_BITS-1:0]  hash_q;
	logic [MW-1:0]          mult_q;
	logic                   bucket_valid_q;
	logic [BUCKET_W-1:0]    bucket_index_q;

	logic                   cfg_write;
	logic                   char_accept;
	logic                   char_nonzero;
	logic [CW-1:0]          size_ext;
	logic [INDEX_BITS:0]    eff_size;
	logic [INDEX_BITS:0]    mult_div;
	logic [MW+INDEX_BITS-1:0] hash_mul;
	logic [MPW-1:0]         mult_mul;
	logic [PW-1:0]          hash_prod;
	logic [PW-1:0]          mult_prod;
	logic [INDEX_BITS-1:0]  hash_rem;
	logic [INDEX_BITS-1:0]  mult_rem;
	logic [INDEX_BITS+BUCKET_W-1:0] hash_wide;
	red_ctrl_t              red_ctrl;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1:2] == REG_TABLE_SIZE) begin
			prdata = APB_DW'(table_size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TSW'(TABLE_SIZE_RESET);
		end else if (cfg_write && paddr[APB_AW-1:2] == REG_TABLE_SIZE) begin
			table_size_q <= pwdata[TSW-1:0];
		end
	end

	// effective table size, clamped to 2 .. 2**INDEX_BITS
	always_comb begin
		size_ext = CW'(table_size_q);
		priority if (size_ext < SIZE_MIN) begin
			size_ext = SIZE_MIN;
		end else if (size_ext > SIZE_TOP) begin
			size_ext = SIZE_TOP;
		end
		eff_size = size_ext[INDEX_BITS:0];
		mult_div = eff_size - 1'b1;
	end

	// input transaction handshake
	assign char_stall   = (state_q != ST_IDLE) || (bucket_valid_q && bucket_stall);
	assign char_accept  = char_valid && !char_stall;
	assign char_nonzero = |char_code;

	// products for the next step
	always_comb begin
		hash_mul  = mult_q * hash_q;
		mult_mul  = mult_q * STEP_W'(HASH_STEP_MULT);
		hash_prod = PW'(hash_mul) + PW'(char_code);
		mult_prod = PW'(mult_mul);
	end

	// reducer control
	always_comb begin
		red_ctrl.load = char_accept && char_nonzero;
		red_ctrl.step = (state_q == ST_RUN);
	end

	ush_reducer u_hash_red (
		.clk       (clk),
		.ctrl      (red_ctrl),
		.product   (hash_prod),
		.divisor   (eff_size),
		.remainder (hash_rem)
	);

	ush_reducer u_mult_red (
		.clk       (clk),
		.ctrl      (red_ctrl),
		.product   (mult_prod),
		.divisor   (mult_div),
		.remainder (mult_rem)
	);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			hash_q  <= '0;
			mult_q  <= MW'(HASH_SEED_MULT);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (char_accept && char_nonzero) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end else if (char_accept) begin
						hash_q <= '0;
						mult_q <= MW'(HASH_SEED_MULT);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					hash_q  <= hash_rem;
					mult_q  <= MW'(mult_rem);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	assign hash_wide = {{BUCKET_W{1'b0}}, hash_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_valid_q <= 1'b0;
		end else if (char_accept && !char_nonzero) begin
			bucket_valid_q <= 1'b1;
		end else if (!bucket_stall) begin
			bucket_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_accept && !char_nonzero) begin
			bucket_index_q <= hash_wide[BUCKET_W-1:0];
		end
	end

	assign bucket_valid = bucket_valid_q;
	assign bucket_index = bucket_index_q;

	// checks
	`USH_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, char_stall)
	`USH_ASSERT_NEXT(a_byte_starts_run, char_accept && char_nonzero, state_q == ST_RUN)
	`USH_ASSERT_NEXT(a_hash_in_range, state_q == ST_DONE, {1'b0, hash_q} < eff_size)
	`USH_ASSERT_NOW(a_result_from_zero, $rose(bucket_valid_q), $past(char_accept && !char_nonzero))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ush_pkg::*;

	// spare register index, writes to it must not change anything
	localparam logic [APB_AW-3:0] REG_SPARE = 1'b1;
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	localparam int ITEM_TARGET = 700;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int IDLE_PCT = 31;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                char_valid = 1'b0;
	logic                char_stall;
	logic [CHAR_W-1:0]   char_code = '0;
	logic                bucket_valid;
	logic                bucket_stall = 1'b0;
	logic [BUCKET_W-1:0] bucket_index;

	// shadow state of the hash datapath
	logic [TSW-1:0]      shadow_table_size = TSW'(TABLE_SIZE_RESET);
	longint unsigned     shadow_hash = 0;
	longint unsigned     shadow_mult = HASH_SEED_MULT;

	logic [BUCKET_W-1:0] expected_buckets[$];
	int                  errors = 0;
	int                  chars_sent = 0;
	bit                  tx_idle_on = 1'b1;
	bit                  rx_idle_on = 1'b1;
	logic                rx_hold = 1'b0;

	universal_string_hash u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.bucket_valid(bucket_valid),
		.bucket_stall(bucket_stall),
		.bucket_index(bucket_index)
	);

	always #HALF_PERIOD clk = ~clk;

	// advance the shadow hash by one byte, a zero byte yields the bucket index
	function automatic void predict_bucket(input logic [CHAR_W-1:0] c, output bit done,
			output logic [BUCKET_W-1:0] idx);
		longint unsigned s;
		s = shadow_table_size;
		if (s < 2)
			s = 2;
		if (s > (64'd1 << INDEX_BITS))
			s = 64'd1 << INDEX_BITS;
		if (c == '0) begin
			done = 1'b1;
			idx = shadow_hash[BUCKET_W-1:0];
			shadow_hash = 0;
			shadow_mult = HASH_SEED_MULT;
		end else begin
			done = 1'b0;
			idx = '0;
			shadow_hash = (shadow_mult * shadow_hash + c) % s;
			shadow_mult = (shadow_mult * HASH_STEP_MULT) % (s - 1);
		end
	endfunction

	// receiver side: random stall plus the long hold-off
	always @(posedge clk) begin
		bucket_stall <= rx_hold || (rx_idle_on && ($urandom_range(99) < IDLE_PCT));
	end

	// compare each bucket transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && bucket_valid === 1'b1 && !bucket_stall) begin
			if (expected_buckets.size() == 0) begin
				$display("%0t: unexpected bucket_index, expected none, actual %0d",
					$time, bucket_index);
				errors++;
			end else if (bucket_index !== expected_buckets[0]) begin
				$display("%0t: bucket_index mismatch, expected %0d, actual %0d",
					$time, expected_buckets[0], bucket_index);
				errors++;
				void'(expected_buckets.pop_front());
			end else begin
				void'(expected_buckets.pop_front());
			end
		end
	end

	// watchdog on cycles with no transaction on any port
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (char_valid && char_stall === 1'b0)
					|| (bucket_valid === 1'b1 && !bucket_stall)
					|| (psel && penable && pready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// one apb write: setup then access
	task automatic write_reg(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_TABLE_SIZE)
			shadow_table_size = value[TSW-1:0];
	endtask

	// offer one byte and hold it until accepted
	task automatic send_char(input logic [CHAR_W-1:0] c);
		bit done;
		logic [BUCKET_W-1:0] idx;
		char_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (char_stall !== 1'b0);
		predict_bucket(c, done, idx);
		if (done)
			expected_buckets.push_back(idx);
		chars_sent++;
		if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_string(input int len, input bit terminate);
		logic [CHAR_W-1:0] c;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: c = 8'hFF;
				1: c = 8'h01;
				default: c = CHAR_W'($urandom_range(1, 255));
			endcase
			send_char(c);
		end
		if (terminate)
			send_char('0);
	endtask

	// sender pauses until every bucket has come back
	task automatic drain_results();
		char_valid <= 1'b0;
		while (expected_buckets.size() != 0)
			@(posedge clk);
	endtask

	// a byte may still be in the reducers, let it finish before writing
	task automatic reconfigure(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(idx, value);
	endtask

	// empty string and a one byte string at the reset table size
	task automatic test_reset_defaults();
		send_char('0);
		send_char(8'h01);
		send_char('0);
	endtask

	// every bit of the byte at both values
	task automatic test_byte_bits();
		send_char(8'h55);
		send_char(8'hAA);
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h01);
		send_char('0);
	endtask

	// table size below, at and above its limits, and upper bits masked off
	task automatic test_table_size_limits();
		logic [APB_DW-1:0] sizes[5];
		sizes = '{32'h0000_0000, 32'h0000_0002, 32'h0001_0000, 32'h0001_FFFF, 32'hFFFE_0400};
		foreach (sizes[i]) begin
			reconfigure(REG_TABLE_SIZE, sizes[i]);
			send_char(8'hFF);
			send_char(8'h7F);
			send_char('0);
		end
	endtask

	// new size takes effect from the next byte, running state kept
	task automatic test_size_change_mid_string();
		reconfigure(REG_TABLE_SIZE, 32'd1024);
		send_char(8'hC8);
		send_char(8'h0D);
		reconfigure(REG_TABLE_SIZE, 32'd97);
		send_char(8'h2A);
		send_char('0);
	endtask

	// writes to an unmapped register are dropped
	task automatic test_spare_register();
		reconfigure(REG_SPARE, 32'd5);
		send_char(8'h09);
		send_char('0);
	endtask

	// receiver holds off while strings keep coming, so the input stalls
	task automatic test_output_hold();
		reconfigure(REG_TABLE_SIZE, 32'd4099);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
			begin
				for (int i = 0; i < 6; i++)
					send_string(2, 1'b1);
			end
		join
		drain_results();
	endtask

	// random sizes and strings, some phases end mid string
	task automatic test_random_strings();
		logic [APB_DW-1:0] size_val;
		int phase;
		int phase_end;
		int len;
		phase = 0;
		while (chars_sent < ITEM_TARGET) begin
			case ($urandom_range(9))
				0: size_val = $urandom_range(1);
				1: size_val = 32'd2;
				2: size_val = 32'd3;
				3: size_val = 32'h0001_0000;
				4: size_val = 32'h0000_FFFF;
				5: size_val = $urandom_range(32'h0001_0001, 32'h0001_FFFF);
				6: size_val = $urandom;
				7, 8: size_val = $urandom_range(2, 64);
				default: size_val = $urandom_range(2, 65536);
			endcase
			if ($urandom_range(7) == 0)
				reconfigure(REG_SPARE, $urandom);
			reconfigure(REG_TABLE_SIZE, size_val);
			// one phase runs with no idling on either side
			tx_idle_on = (phase != 2);
			rx_idle_on = (phase != 2);
			phase_end = chars_sent + ((phase == 2) ? 120 : 50);
			while (chars_sent < phase_end) begin
				case ($urandom_range(19))
					0, 1: len = 0;
					2, 3, 4: len = $urandom_range(7, 20);
					5: len = 40;
					default: len = $urandom_range(1, 6);
				endcase
				send_string(len, 1'b1);
			end
			if ($urandom_range(2) == 0)
				send_string($urandom_range(1, 4), 1'b0);
			phase++;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_char('0);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_byte_bits();
		test_table_size_limits();
		test_size_change_mid_string();
		test_spare_register();
		test_output_hold();
		test_random_strings();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
